FILE: design/timed_note_event_queue_assert.svh
// Assertion macros for the timed note event queue.
`ifndef TIMED_NOTE_EVENT_QUEUE_ASSERT_SVH
`define TIMED_NOTE_EVENT_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that cons holds in the same cycle as ante.
`define TNEQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define TNEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TNEQ_ASSERT_IMPLY(lbl, ante, cons, msg)
`define TNEQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/tneq_pkg.sv
// Types and constants shared by the timed note event queue.
`timescale 1ns / 1ps

package tneq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TIME_W          = 48;
  localparam int WORD_W          = 32;
  localparam int PROD_W          = 26;
  localparam int US_PER_MS       = 1000;
  localparam int CHANNELS        = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Operation codes
  localparam logic [1:0] MODE_SET_TIME = 2'd0;
  localparam logic [1:0] MODE_NOTE     = 2'd1;
  localparam logic [1:0] MODE_CALLBACK = 2'd2;
  localparam logic [1:0] MODE_TAKE     = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_NONE = 2'd2;

  // Event kinds
  localparam logic [1:0] KIND_ON  = 2'd0;
  localparam logic [1:0] KIND_OFF = 2'd1;
  localparam logic [1:0] KIND_CB  = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic [TIME_W-1:0]        time_us;
    logic [6:0]               note;
    logic [6:0]               velocity;
    logic [15:0]              length_ms;
    logic [7:0]               channel;
    logic signed [WORD_W-1:0] word_a;
    logic signed [WORD_W-1:0] word_b;
    logic signed [WORD_W-1:0] word_c;
  } item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [1:0]               event_kind;
    logic [TIME_W-1:0]        event_time;
    logic [3:0]               out_channel;
    logic [6:0]               out_note;
    logic [6:0]               out_velocity;
    logic signed [WORD_W-1:0] out_word_a;
    logic signed [WORD_W-1:0] out_word_b;
    logic signed [WORD_W-1:0] out_word_c;
  } result_t;

  // One queue entry; a note keeps channel, note and velocity in the words
  typedef struct packed {
    logic [TIME_W-1:0] time_us;
    logic [1:0]        kind;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic [WORD_W-1:0] word_c;
  } entry_t;

endpackage

FILE: design/tneq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tneq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/timed_note_event_queue.sv
// Time-sorted note and callback event queue. One transaction on req runs one
// operation (set the pending time, schedule a note, schedule a callback, or
// take the due head event) and yields exactly one transaction on rsp. The
// entries live in a circular buffer in one RAM with a registered read port.
// An event due at or before the head is written in front of the head in one
// step; any other event is placed by a backward scan from the tail that moves
// one entry up per cycle until it meets an entry not later than itself. A note
// makes two inserts and a callback one. req_stall is high while an operation
// runs; the result waits in the rsp register, so the next request is taken
// while an earlier result is still stalled.
`timescale 1ns / 1ps
`include "timed_note_event_queue_assert.svh"

module timed_note_event_queue #(
  parameter int QUEUE_DEPTH = tneq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  tneq_pkg::item_t   req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output tneq_pkg::result_t rsp,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data
);

  import tneq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b0_0000_0001,
    ST_DECODE    = 9'b0_0000_0010,
    ST_MUL       = 9'b0_0000_0100,
    ST_ADD       = 9'b0_0000_1000,
    ST_INS_HEAD  = 9'b0_0001_0000,
    ST_INS_HWAIT = 9'b0_0010_0000,
    ST_SCAN      = 9'b0_0100_0000,
    ST_TAKE_WAIT = 9'b0_1000_0000,
    ST_DONE      = 9'b1_0000_0000
  } state_t;

  state_t             state;
  item_t              item;
  entry_t             ins;
  result_t            res;
  logic [CNT_W-1:0]   count;
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   slot;
  logic [PTR_W-1:0]   src;
  logic [TIME_W-1:0]  pending_time;
  logic [TIME_W-1:0]  off_time;
  logic [PROD_W-1:0]  prod;
  logic [3:0]         default_channel;
  logic               second;

  logic [PTR_W:0]     tail_sum;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W-1:0]   tail_dec;
  logic [PTR_W-1:0]   head_dec;
  logic [PTR_W-1:0]   head_inc;
  logic [PTR_W-1:0]   src_dec;
  logic [TIME_W:0]    off_sum;
  logic [3:0]         note_ch;
  logic               ram_wr_en;
  logic [PTR_W-1:0]   ram_wr_addr;
  entry_t             ram_wr_data;
  logic               ram_rd_en;
  logic [PTR_W-1:0]   ram_rd_addr;
  entry_t             ram_rd_data;
  logic               ins_fin;
  logic               ins_front;
  logic               rsp_load;

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - PTR_W'(1);
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  // Entry storage
  tneq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Pointer arithmetic around the circular buffer
  assign tail_sum = {1'b0, head} + (PTR_W + 1)'(count);
  assign tail     = (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH)) ?
                    PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
  assign tail_dec = ptr_dec(tail);
  assign head_dec = ptr_dec(head);
  assign head_inc = ptr_inc(head);
  assign src_dec  = ptr_dec(src);

  // Note-off time with saturation
  assign off_sum = {1'b0, pending_time} + (TIME_W + 1)'(prod);
  assign note_ch = (item.channel < 8'(CHANNELS)) ? item.channel[3:0] : default_channel;

  assign req_stall = (state != ST_IDLE);
  assign rsp_load  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);

  // Drive the RAM ports from the sequencer state
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = slot;
    ram_wr_data = ins;
    ram_rd_en   = 1'b0;
    ram_rd_addr = head;
    ins_fin     = 1'b0;
    ins_front   = 1'b0;
    unique case (state)
      ST_DECODE: begin
        ram_rd_en = (item.mode == MODE_TAKE) && (count != '0);
      end
      ST_INS_HEAD: begin
        if (count == '0) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = head_dec;
          ins_fin     = 1'b1;
          ins_front   = 1'b1;
        end else begin
          ram_rd_en = 1'b1;
        end
      end
      ST_INS_HWAIT: begin
        if (ins.time_us <= ram_rd_data.time_us) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = head_dec;
          ins_fin     = 1'b1;
          ins_front   = 1'b1;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = tail_dec;
        end
      end
      ST_SCAN: begin
        ram_wr_en = 1'b1;
        if (ram_rd_data.time_us > ins.time_us) begin
          // move the later entry up and read the next one down
          ram_wr_data = ram_rd_data;
          ram_rd_en   = 1'b1;
          ram_rd_addr = src_dec;
        end else begin
          ins_fin = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_channel <= '0;
    end else if (cfg_wr_en) begin
      default_channel <= cfg_wr_data;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      head         <= '0;
      pending_time <= '0;
      second       <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            item  <= req;
            res   <= '0;
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          unique case (item.mode)
            MODE_SET_TIME: begin
              pending_time <= item.time_us;
              res.status   <= STATUS_OK;
              state        <= ST_DONE;
            end
            MODE_NOTE: begin
              if (count > CNT_W'(QUEUE_DEPTH - 2)) begin
                res.status <= STATUS_FULL;
                state      <= ST_DONE;
              end else begin
                res.status <= STATUS_OK;
                state      <= ST_MUL;
              end
            end
            MODE_CALLBACK: begin
              if (count == CNT_W'(QUEUE_DEPTH)) begin
                res.status <= STATUS_FULL;
                state      <= ST_DONE;
              end else begin
                res.status  <= STATUS_OK;
                ins.time_us <= pending_time;
                ins.kind    <= KIND_CB;
                ins.word_a  <= item.word_a;
                ins.word_b  <= item.word_b;
                ins.word_c  <= item.word_c;
                second      <= 1'b0;
                state       <= ST_INS_HEAD;
              end
            end
            MODE_TAKE: begin
              if (count == '0) begin
                res.status <= STATUS_NONE;
                state      <= ST_DONE;
              end else begin
                state <= ST_TAKE_WAIT;
              end
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_MUL: begin
          prod  <= PROD_W'(item.length_ms) * PROD_W'(US_PER_MS);
          state <= ST_ADD;
        end
        ST_ADD: begin
          off_time    <= off_sum[TIME_W] ? TIME_MAX : off_sum[TIME_W-1:0];
          ins.time_us <= pending_time;
          ins.kind    <= KIND_ON;
          ins.word_a  <= WORD_W'(note_ch);
          ins.word_b  <= WORD_W'(item.note);
          ins.word_c  <= WORD_W'(item.velocity);
          second      <= 1'b1;
          state       <= ST_INS_HEAD;
        end
        ST_INS_HEAD: begin
          if (!ins_fin) begin
            state <= ST_INS_HWAIT;
          end
        end
        ST_INS_HWAIT: begin
          if (!ins_fin) begin
            slot  <= tail;
            src   <= tail_dec;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!ins_fin) begin
            slot <= src;
            src  <= src_dec;
          end
        end
        ST_TAKE_WAIT: begin
          if (ram_rd_data.time_us <= item.time_us) begin
            res.status     <= STATUS_OK;
            res.event_kind <= ram_rd_data.kind;
            res.event_time <= ram_rd_data.time_us;
            if (ram_rd_data.kind == KIND_CB) begin
              res.out_word_a <= signed'(ram_rd_data.word_a);
              res.out_word_b <= signed'(ram_rd_data.word_b);
              res.out_word_c <= signed'(ram_rd_data.word_c);
            end else begin
              res.out_channel  <= ram_rd_data.word_a[3:0];
              res.out_note     <= ram_rd_data.word_b[6:0];
              res.out_velocity <= ram_rd_data.word_c[6:0];
            end
            head  <= head_inc;
            count <= count - CNT_W'(1);
          end else begin
            res.status <= STATUS_NONE;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Finish an insert: grow the queue, then queue the note-off or report
      if (ins_fin) begin
        count <= count + CNT_W'(1);
        if (ins_front) begin
          head <= head_dec;
        end
        if (second) begin
          ins.time_us <= off_time;
          ins.kind    <= KIND_OFF;
          ins.word_c  <= '0;
          second      <= 1'b0;
          state       <= ST_INS_HEAD;
        end else begin
          state <= ST_DONE;
        end
      end
    end
  end

  `TNEQ_ASSERT_IMPLY(a_count_max, 1'b1, count <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
  `TNEQ_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "not busy after req")
  `TNEQ_ASSERT_NEXT(a_count_step, 1'b1,
                    (count == $past(count)) || (count == $past(count) + CNT_W'(1))
                    || ($past(count) == count + CNT_W'(1)), "count jumped")

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the timed note event queue.
`timescale 1ns / 1ps

module testbench;
  import tneq_pkg::*;

  localparam int DEPTH     = QUEUE_DEPTH_DEF;
  localparam int MS_TO_US  = 1000;
  localparam int NUM_CHANS = 16;

  logic    clk;
  logic    rst;
  logic    req_valid;
  logic    req_stall;
  item_t   req;
  logic    rsp_valid;
  logic    rsp_stall;
  result_t rsp;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;

  timed_note_event_queue dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Mirror of the event schedule, kept sorted by time
  entry_t            sched[$];
  logic [TIME_W-1:0] pend_time = '0;
  logic [3:0]        dflt_channel = '0;

  result_t expected_rsp_q[$];

  int err_count = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_taken   = 0;
  int n_full    = 0;
  int n_none    = 0;
  int hold_left = 0;
  bit no_idle   = 1'b0;
  logic [TIME_W-1:0] now_us = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("timeout: %0d transactions still expected", expected_rsp_q.size());
    $display("testbench: errors");
    $finish;
  end

  // Place one event after the last entry not later than it, or in front of the head
  function automatic void insert_entry(input logic [TIME_W-1:0] t, input logic [1:0] k,
                                       input logic [WORD_W-1:0] a, b, c);
    entry_t e;
    int     pos;
    e.time_us = t;
    e.kind    = k;
    e.word_a  = a;
    e.word_b  = b;
    e.word_c  = c;
    if (sched.size() == 0 || t <= sched[0].time_us) begin
      pos = 0;
    end else begin
      pos = 1;
      while (pos < sched.size() && sched[pos].time_us <= t) pos++;
    end
    sched.insert(pos, e);
  endfunction

  // Apply one operation to the mirror and return the result it must give
  function automatic result_t apply_to_schedule(input item_t it);
    result_t         r;
    entry_t          e;
    logic [TIME_W:0] off_sum;
    logic [3:0]      ch;
    r = '0;
    case (it.mode)
      MODE_SET_TIME: begin
        pend_time = it.time_us;
      end
      MODE_NOTE: begin
        if (sched.size() + 2 > DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          ch = (it.channel < NUM_CHANS) ? it.channel[3:0] : dflt_channel;
          off_sum = {1'b0, pend_time} + (49'(it.length_ms) * 49'(MS_TO_US));
          if (off_sum > {1'b0, TIME_MAX}) off_sum = {1'b0, TIME_MAX};
          insert_entry(pend_time, KIND_ON, 32'(ch), 32'(it.note), 32'(it.velocity));
          insert_entry(off_sum[TIME_W-1:0], KIND_OFF, 32'(ch), 32'(it.note), 32'd0);
        end
      end
      MODE_CALLBACK: begin
        if (sched.size() + 1 > DEPTH) r.status = STATUS_FULL;
        else insert_entry(pend_time, KIND_CB, it.word_a, it.word_b, it.word_c);
      end
      default: begin
        if (sched.size() == 0 || sched[0].time_us > it.time_us) begin
          r.status = STATUS_NONE;
        end else begin
          e = sched[0];
          sched.delete(0);
          r.status     = STATUS_OK;
          r.event_kind = e.kind;
          r.event_time = e.time_us;
          if (e.kind == KIND_CB) begin
            r.out_word_a = e.word_a;
            r.out_word_b = e.word_b;
            r.out_word_c = e.word_c;
          end else begin
            r.out_channel  = e.word_a[3:0];
            r.out_note     = e.word_b[6:0];
            r.out_velocity = e.word_c[6:0];
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic item_t rand_item(input logic [1:0] m);
    item_t it;
    it.mode      = m;
    it.time_us   = {16'($urandom()), 32'($urandom())};
    it.note      = 7'($urandom());
    it.velocity  = 7'($urandom());
    it.length_ms = 16'($urandom());
    it.channel   = 8'($urandom());
    it.word_a    = 32'($urandom());
    it.word_b    = 32'($urandom());
    it.word_c    = 32'($urandom());
    return it;
  endfunction

  // Offer one transaction, hold it until accepted, then record its result
  task automatic send_item(input item_t it);
    int gap;
    if (!no_idle && $urandom_range(0, 99) < 7) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 12);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    expected_rsp_q.push_back(apply_to_schedule(it));
    n_sent++;
  endtask

  task automatic send_set(input logic [TIME_W-1:0] t);
    item_t it;
    it = rand_item(MODE_SET_TIME);
    it.time_us = t;
    send_item(it);
  endtask

  task automatic send_take(input logic [TIME_W-1:0] t);
    item_t it;
    it = rand_item(MODE_TAKE);
    it.time_us = t;
    send_item(it);
  endtask

  task automatic send_note(input logic [7:0] ch, input logic [6:0] n, v,
                           input logic [15:0] len);
    item_t it;
    it = rand_item(MODE_NOTE);
    it.channel   = ch;
    it.note      = n;
    it.velocity  = v;
    it.length_ms = len;
    send_item(it);
  endtask

  task automatic send_callback(input logic [WORD_W-1:0] a, b, c);
    item_t it;
    it = rand_item(MODE_CALLBACK);
    it.word_a = a;
    it.word_b = b;
    it.word_c = c;
    send_item(it);
  endtask

  // Stop offering and wait until every outstanding result has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_rsp_q.size() != 0);
  endtask

  // Take every scheduled event
  task automatic drain_schedule();
    while (sched.size() > 0) send_take(TIME_MAX);
  endtask

  task automatic write_default_channel(input logic [3:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    dflt_channel = v;
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v, got_v);
    if (got_v !== want_v) begin
      err_count++;
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
    end
  endtask

  // Receive side: check each accepted transaction, then pick the next stall
  initial begin : rsp_side
    result_t want;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        if (expected_rsp_q.size() == 0) begin
          err_count++;
          $error("result transaction with nothing expected: status %0h", rsp.status);
        end else begin
          want = expected_rsp_q[0];
          expected_rsp_q.delete(0);
          n_checked++;
          if (want.status == STATUS_FULL) n_full++;
          else if (want.status == STATUS_NONE) n_none++;
          else if (want.event_time != '0 || want.event_kind != '0) n_taken++;
          check_field("status",       64'(want.status),       64'(rsp.status));
          check_field("event_kind",   64'(want.event_kind),   64'(rsp.event_kind));
          check_field("event_time",   64'(want.event_time),   64'(rsp.event_time));
          check_field("out_channel",  64'(want.out_channel),  64'(rsp.out_channel));
          check_field("out_note",     64'(want.out_note),     64'(rsp.out_note));
          check_field("out_velocity", 64'(want.out_velocity), 64'(rsp.out_velocity));
          check_field("out_word_a",   64'(want.out_word_a),   64'(rsp.out_word_a));
          check_field("out_word_b",   64'(want.out_word_b),   64'(rsp.out_word_b));
          check_field("out_word_c",   64'(want.out_word_c),   64'(rsp.out_word_c));
        end
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= (!no_idle && $urandom_range(0, 99) < 7);
      end
    end
  end

  // Empty queue, ties with the head, default channel, word extremes, saturation
  task automatic test_directed();
    send_take(48'd0);
    send_set(48'd1000);
    send_note(8'd3, 7'd60, 7'd100, 16'd5);
    send_callback(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_note(8'd200, 7'd127, 7'd127, 16'd0);
    send_set(48'd500);
    send_callback(32'd0, 32'd0, 32'd0);
    send_take(48'd499);
    repeat (5) send_take(48'd1000);
    send_take(48'd6000);
    send_set(TIME_MAX - 48'd5);
    send_note(8'd15, 7'd0, 7'd0, 16'hffff);
    send_callback(32'($urandom()), 32'($urandom()), 32'($urandom()));
    send_take(TIME_MAX - 48'd6);
    repeat (4) send_take(TIME_MAX);
    send_set(TIME_MAX);
    send_callback(32'($urandom()), 32'($urandom()), 32'($urandom()));
    send_take(48'd0);
    send_take(TIME_MAX);
  endtask

  // Channels of 16 and above fall back to the register
  task automatic test_default_channel();
    logic [3:0] vals [3];
    vals[0] = 4'd15;
    vals[1] = 4'd0;
    vals[2] = 4'($urandom_range(1, 14));
    foreach (vals[k]) begin
      write_default_channel(vals[k]);
      send_set(48'($urandom_range(0, 100000)));
      send_note(8'd16, 7'($urandom()), 7'($urandom()), 16'($urandom_range(0, 5)));
      send_note(8'd255, 7'($urandom()), 7'($urandom()), 16'($urandom_range(0, 5)));
      send_note(8'($urandom_range(17, 254)), 7'($urandom()), 7'($urandom()),
                16'($urandom_range(0, 5)));
      send_note(8'd15, 7'($urandom()), 7'($urandom()), 16'($urandom_range(0, 5)));
      drain_schedule();
    end
  endtask

  // Fill to the last free entry, hit the full cases, then empty again
  task automatic test_queue_full();
    drain_schedule();
    while (sched.size() < DEPTH - 1) begin
      if ($urandom_range(0, 3) == 0) send_set(48'($urandom_range(0, 40)));
      if (sched.size() <= DEPTH - 3 && $urandom_range(0, 1) == 1)
        send_note(8'($urandom()), 7'($urandom()), 7'($urandom()), 16'($urandom_range(0, 3)));
      else
        send_callback(32'($urandom()), 32'($urandom()), 32'($urandom()));
    end
    send_note(8'($urandom()), 7'($urandom()), 7'($urandom()), 16'($urandom()));
    send_callback(32'($urandom()), 32'($urandom()), 32'($urandom()));
    send_callback(32'($urandom()), 32'($urandom()), 32'($urandom()));
    send_note(8'($urandom()), 7'($urandom()), 7'($urandom()), 16'($urandom()));
    drain_schedule();
    send_take(TIME_MAX);
  endtask

  // Hold the receiver off long enough that the block stalls its input
  task automatic test_backpressure();
    wait_drained();
    no_idle   = 1'b1;
    hold_left = 300;
    for (int i = 0; i < 12; i++) begin
      case (i % 3)
        0:       send_callback(32'($urandom()), 32'($urandom()), 32'($urandom()));
        1:       send_note(8'($urandom()), 7'($urandom()), 7'($urandom()), 16'($urandom()));
        default: send_take(TIME_MAX);
      endcase
    end
    wait_drained();
    no_idle = 1'b0;
  endtask

  // Mostly plausible traffic around a moving current time, some raw noise
  task automatic test_random_traffic(input int count);
    item_t it;
    int    pick;
    int    sub;
    bit    fill_bias;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) fill_bias = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      sub  = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < 4) begin
        it = rand_item(2'($urandom()));
      end else if (pick < 15) begin
        it = rand_item(MODE_SET_TIME);
        if (sub < 8) it.time_us = now_us + 48'($urandom_range(0, 3000));
        else if (sub == 9) it.time_us = TIME_MAX - 48'($urandom_range(0, 200000));
      end else if (pick < (fill_bias ? 50 : 30)) begin
        it = rand_item(MODE_NOTE);
        if (sub < 7) it.length_ms = 16'($urandom_range(0, 8));
        else if (sub == 9) it.length_ms = 16'hffff;
        if ($urandom_range(0, 9) < 6) it.channel = 8'($urandom_range(0, 15));
      end else if (pick < (fill_bias ? 75 : 45)) begin
        it = rand_item(MODE_CALLBACK);
      end else begin
        it = rand_item(MODE_TAKE);
        if (sub < 7) begin
          now_us = now_us + 48'($urandom_range(0, 1500));
          it.time_us = now_us;
        end else if (sub == 7) begin
          it.time_us = now_us - 48'($urandom_range(0, 3000));
        end else if (sub == 8) begin
          it.time_us = TIME_MAX;
        end
      end
      send_item(it);
    end
  endtask

  initial begin
    rst         <= 1'b1;
    req_valid   <= 1'b0;
    req         <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_default_channel();
    test_queue_full();
    test_backpressure();

    // Random phases, one of them with no idling on either side
    write_default_channel(4'd15);
    test_random_traffic(260);
    write_default_channel(4'($urandom()));
    no_idle = 1'b1;
    test_random_traffic(260);
    no_idle = 1'b0;
    write_default_channel(4'd0);
    test_random_traffic(260);
    write_default_channel(4'($urandom()));
    test_random_traffic(260);

    wait_drained();
    repeat (40) @(posedge clk);
    if (expected_rsp_q.size() != 0) begin
      err_count++;
      $error("%0d result transactions never arrived", expected_rsp_q.size());
    end
    $display("sent %0d requests, checked %0d results (%0d events taken, %0d full, %0d none due)",
             n_sent, n_checked, n_taken, n_full, n_none);
    $display("covered sorted inserts, a full queue, saturated note-offs, and back-pressure");
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
